// ===== rtl/core/bfs_pkg.sv =====
`timescale 1ns / 1ps

package bfs_pkg;

    // field widths fixed by the event format
    localparam int ACTION_BITS   = 2;
    localparam int CHARGE_BITS   = 11;
    localparam int VOLTAGE_BITS  = 16;
    localparam int MODE_BITS     = 2;
    localparam int REQ_BITS      = 2;
    localparam int CHG_LIM_BITS  = 10;
    localparam int TRIGGER_BITS  = 16;
    localparam int RADIUS_BITS   = 16;
    localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    // event kinds
    typedef enum logic [ACTION_BITS-1:0] {
        ACT_BATTERY  = 2'd0,
        ACT_STATE    = 2'd1,
        ACT_POSITION = 2'd2,
        ACT_TICK     = 2'd3
    } t_action;

    // flight modes as reported by the vehicle
    typedef enum logic [MODE_BITS-1:0] {
        MODE_OFFBOARD  = 2'd0,
        MODE_AUTO_RTL  = 2'd1,
        MODE_AUTO_LAND = 2'd2,
        MODE_OTHER     = 2'd3
    } t_mode;

    // mode change requests
    localparam logic [REQ_BITS-1:0] REQ_NONE = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_LAND = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_RTL  = 2'd2;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_CHARGE  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_VOLTAGE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TRIGGER     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RADIUS      = 3'd3;

    // register reset values
    localparam logic [CHG_LIM_BITS-1:0]   LOW_CHARGE_RST  = 10'd200;
    localparam logic [VOLTAGE_BITS-1:0]   LOW_VOLTAGE_RST = 16'd22000;
    localparam logic [TRIGGER_BITS-1:0]   TRIGGER_RST     = 16'd100;
    localparam logic [RADIUS_SQ_BITS-1:0] RADIUS_SQ_RST   = 32'd40000;

    // current thresholds handed to the datapath
    typedef struct packed {
        logic [CHG_LIM_BITS-1:0]   low_charge_limit;
        logic [VOLTAGE_BITS-1:0]   low_voltage_limit_mv;
        logic [TRIGGER_BITS-1:0]   trigger_ticks;
        logic [RADIUS_SQ_BITS-1:0] radius_sq;
    } t_cfg;

endpackage

// ===== rtl/core/bfs_cfg_regs.sv =====
`timescale 1ns / 1ps

module bfs_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bfs_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [bfs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output bfs_pkg::t_cfg                       o_cfg
);
    import bfs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // decode the write; the radius is kept squared for the arrival compare
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOW_CHARGE:  n_cfg.low_charge_limit     = i_cfg_data[CHG_LIM_BITS-1:0];
                CFG_LOW_VOLTAGE: n_cfg.low_voltage_limit_mv = i_cfg_data[VOLTAGE_BITS-1:0];
                CFG_TRIGGER:     n_cfg.trigger_ticks        = i_cfg_data[TRIGGER_BITS-1:0];
                CFG_RADIUS: begin
                    n_cfg.radius_sq = RADIUS_SQ_BITS'(i_cfg_data[RADIUS_BITS-1:0])
                                    * RADIUS_SQ_BITS'(i_cfg_data[RADIUS_BITS-1:0]);
                end
                default: ;
            endcase
        end
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_charge_limit     <= LOW_CHARGE_RST;
            r_cfg.low_voltage_limit_mv <= LOW_VOLTAGE_RST;
            r_cfg.trigger_ticks        <= TRIGGER_RST;
            r_cfg.radius_sq            <= RADIUS_SQ_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/battery_failsafe_supervisor.sv =====
`timescale 1ns / 1ps

// Battery failsafe supervisor. Each accepted event (battery sample, vehicle
// state, position, control tick) gives exactly one result, in order. The block
// takes one event per clock cycle unless output backpressure holds it. An
// accepted event is held in the input register and then moves to the result
// register, from which its result is presented; both stages hold under output
// backpressure. A position update squares |x| and |y| as it is stored, so a
// tick right after it compares the stored sum against the squared arrival
// radius with one add and compare. Writing the radius register squares it on
// the spot. Configuration must be written only while no event is in flight.
// There is no start-up sweep after reset.
module battery_failsafe_supervisor #(
    parameter int POS_BITS  = 24,
    parameter int TIME_BITS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // configuration
    input  logic                                      i_cfg_we,
    input  logic [bfs_pkg::CFG_INDEX_BITS-1:0]        i_cfg_index,
    input  logic [bfs_pkg::CFG_DATA_BITS-1:0]         i_cfg_data,
    // event channel
    input  logic                                      i_in_valid,
    output logic                                      o_in_ready,
    input  logic [bfs_pkg::ACTION_BITS-1:0]           i_action,
    input  logic signed [bfs_pkg::CHARGE_BITS-1:0]    i_charge_milli,
    input  logic [bfs_pkg::VOLTAGE_BITS-1:0]          i_voltage_mv,
    input  logic                                      i_armed_flag,
    input  logic [bfs_pkg::MODE_BITS-1:0]             i_flight_mode,
    input  logic signed [POS_BITS-1:0]                i_pos_x_mm,
    input  logic signed [POS_BITS-1:0]                i_pos_y_mm,
    input  logic signed [POS_BITS-1:0]                i_pos_z_mm,
    input  logic                                      i_commander_present,
    // result channel
    output logic                                      o_out_valid,
    input  logic                                      i_out_ready,
    output logic                                      o_commander_land,
    output logic                                      o_publish_setpoint,
    output logic signed [POS_BITS-1:0]                o_setpoint_z_mm,
    output logic [bfs_pkg::REQ_BITS-1:0]              o_mode_request,
    output logic                                      o_failsafe_active,
    output logic                                      o_low_pending
);
    import bfs_pkg::*;

    localparam int SQ_BITS  = 2 * POS_BITS;
    localparam int SUM_BITS = SQ_BITS + 1;

    t_cfg w_cfg;

    bfs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // input register
    logic                       r_in_valid;
    t_action                    r_in_action;
    logic [CHARGE_BITS-1:0]     r_in_charge;
    logic [VOLTAGE_BITS-1:0]    r_in_voltage;
    logic                       r_in_armed;
    t_mode                      r_in_mode;
    logic [POS_BITS-1:0]        r_in_x;
    logic [POS_BITS-1:0]        r_in_y;
    logic [POS_BITS-1:0]        r_in_z;
    logic                       r_in_cmdr;

    // supervisor state
    logic [TIME_BITS-1:0]       r_tick_count,     n_tick_count;
    logic [TIME_BITS-1:0]       r_low_start,      n_low_start;
    logic                       r_low_seen,       n_low_seen;
    logic                       r_latched,        n_latched;
    logic                       r_armed,          n_armed;
    t_mode                      r_mode,           n_mode;
    logic                       r_pos_known,      n_pos_known;
    logic [POS_BITS-1:0]        r_z,              n_z;
    logic [SQ_BITS-1:0]         r_sq_x,           n_sq_x;
    logic [SQ_BITS-1:0]         r_sq_y,           n_sq_y;

    // result register
    logic                       r_out_valid;
    logic                       r_out_land,       n_out_land;
    logic                       r_out_pub,        n_out_pub;
    logic [POS_BITS-1:0]        r_out_z,          n_out_z;
    logic [REQ_BITS-1:0]        r_out_req,        n_out_req;

    logic                       w_fire;
    logic [POS_BITS-1:0]        w_mag_x;
    logic [POS_BITS-1:0]        w_mag_y;
    logic [SUM_BITS-1:0]        w_dist_sq;
    logic                       w_arrived;
    logic                       w_charge_low;
    logic                       w_voltage_low;
    logic [TIME_BITS-1:0]       w_elapsed;

    // handshake: the work stage moves when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_action  <= t_action'(i_action);
            r_in_charge  <= i_charge_milli;
            r_in_voltage <= i_voltage_mv;
            r_in_armed   <= i_armed_flag;
            r_in_mode    <= t_mode'(i_flight_mode);
            r_in_x       <= i_pos_x_mm;
            r_in_y       <= i_pos_y_mm;
            r_in_z       <= i_pos_z_mm;
            r_in_cmdr    <= i_commander_present;
        end
    end

    // magnitudes of the incoming position, squared as it is stored
    assign w_mag_x = r_in_x[POS_BITS-1] ? (~r_in_x + 1'b1) : r_in_x;
    assign w_mag_y = r_in_y[POS_BITS-1] ? (~r_in_y + 1'b1) : r_in_y;

    // arrival test on the stored squares
    assign w_dist_sq = {1'b0, r_sq_x} + {1'b0, r_sq_y};
    assign w_arrived = w_dist_sq < SUM_BITS'(w_cfg.radius_sq);

    // battery thresholds; negative charge and zero voltage mean unknown
    assign w_charge_low  = !r_in_charge[CHARGE_BITS-1]
                        && (r_in_charge[CHG_LIM_BITS-1:0] < w_cfg.low_charge_limit);
    assign w_voltage_low = (r_in_voltage != '0)
                        && (r_in_voltage < w_cfg.low_voltage_limit_mv);
    assign w_elapsed     = r_tick_count - r_low_start;

    // state update
    always_comb begin
        n_tick_count = r_tick_count;
        n_low_start  = r_low_start;
        n_low_seen   = r_low_seen;
        n_latched    = r_latched;
        n_armed      = r_armed;
        n_mode       = r_mode;
        n_pos_known  = r_pos_known;
        n_z          = r_z;
        n_sq_x       = r_sq_x;
        n_sq_y       = r_sq_y;
        if (w_fire) begin
            case (r_in_action)
                ACT_BATTERY: begin
                    if (r_armed && !r_latched) begin
                        if (w_charge_low || w_voltage_low) begin
                            if (!r_low_seen) begin
                                n_low_start = r_tick_count;
                                n_low_seen  = 1'b1;
                            end else if (w_elapsed > TIME_BITS'(w_cfg.trigger_ticks)) begin
                                n_latched = 1'b1;
                            end
                        end else begin
                            n_low_seen = 1'b0;
                        end
                    end
                end
                ACT_STATE: begin
                    n_armed = r_in_armed;
                    n_mode  = r_in_mode;
                    if (!r_in_armed && r_latched) begin
                        n_latched  = 1'b0;
                        n_low_seen = 1'b0;
                    end
                end
                ACT_POSITION: begin
                    n_z         = r_in_z;
                    n_sq_x      = SQ_BITS'(w_mag_x) * SQ_BITS'(w_mag_x);
                    n_sq_y      = SQ_BITS'(w_mag_y) * SQ_BITS'(w_mag_y);
                    n_pos_known = 1'b1;
                end
                ACT_TICK: begin
                    n_tick_count = r_tick_count + 1'b1;
                end
                default: ;
            endcase
        end
    end

    // tick actions, in priority order
    always_comb begin
        n_out_land = 1'b0;
        n_out_pub  = 1'b0;
        n_out_z    = '0;
        n_out_req  = REQ_NONE;
        if (r_in_action == ACT_TICK && r_latched && r_armed) begin
            if (r_in_cmdr) begin
                n_out_land = 1'b1;
            end else if (r_mode == MODE_OFFBOARD) begin
                if (!r_pos_known) begin
                    n_out_req = REQ_LAND;
                end else begin
                    n_out_pub = 1'b1;
                    n_out_z   = r_z;
                    if (w_arrived) begin
                        n_out_req = REQ_LAND;
                    end
                end
            end else if (r_mode == MODE_OTHER) begin
                n_out_req = REQ_RTL;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count <= '0;
            r_low_start  <= '0;
            r_low_seen   <= 1'b0;
            r_latched    <= 1'b0;
            r_armed      <= 1'b0;
            r_mode       <= MODE_OTHER;
            r_pos_known  <= 1'b0;
            r_z          <= '0;
            r_sq_x       <= '0;
            r_sq_y       <= '0;
        end else begin
            r_tick_count <= n_tick_count;
            r_low_start  <= n_low_start;
            r_low_seen   <= n_low_seen;
            r_latched    <= n_latched;
            r_armed      <= n_armed;
            r_mode       <= n_mode;
            r_pos_known  <= n_pos_known;
            r_z          <= n_z;
            r_sq_x       <= n_sq_x;
            r_sq_y       <= n_sq_y;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    logic r_out_fs;
    logic r_out_low;

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_land <= n_out_land;
            r_out_pub  <= n_out_pub;
            r_out_z    <= n_out_z;
            r_out_req  <= n_out_req;
            r_out_fs   <= n_latched;
            r_out_low  <= n_low_seen;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_commander_land   = r_out_land;
    assign o_publish_setpoint = r_out_pub;
    assign o_setpoint_z_mm    = r_out_z;
    assign o_mode_request     = r_out_req;
    assign o_failsafe_active  = r_out_fs;
    assign o_low_pending      = r_out_low;

endmodule
